// ----- hdl/lgs_pkg.sv -----
// Shared types and constants for the life grid generation step block.
// Holds grid dimensions, the command code enum and the control struct.
// No dependencies.
package lgs_pkg;

  localparam int unsigned Rows   = 32;
  localparam int unsigned Cols   = 32;
  localparam int unsigned FieldW = 5;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_STEP  = 2'd2,
    MODE_NONE  = 2'd3
  } lgs_mode_e;

  // Decoded command, broadcast to every cell of the grid
  typedef struct packed {
    logic write;
    logic read;
    logic step;
  } lgs_ctl_t;

endpackage

// ----- hdl/lgs_cell.sv -----
// One site of the life grid: holds its live bit and applies B3/S23.
// Depends on lgs_pkg for the control struct.
module lgs_cell import lgs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lgs_ctl_t ctl_i,
  input  logic     sel_i,
  input  logic     wdata_i,
  input  logic [7:0] nbr_i,
  output logic     live_o,
  output logic     rd_o
);

  logic       live_q, live_d;
  logic [3:0] count;
  logic       next_live;

  assign count = 4'($countones(nbr_i));

  always_comb begin
    case (count)
      4'd2:    next_live = live_q;
      4'd3:    next_live = 1'b1;
      default: next_live = 1'b0;
    endcase
  end

  always_comb begin
    live_d = live_q;
    if (ctl_i.write && sel_i) begin
      live_d = wdata_i;
    end else if (ctl_i.step) begin
      live_d = next_live;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else begin
      live_q <= live_d;
    end
  end

  assign live_o = live_q;
  assign rd_o   = ctl_i.read & sel_i & live_q;

endmodule

// ----- hdl/lgs_array.sv -----
// Grid of lgs_cell sites with dead-cell padding around the border.
// Depends on lgs_pkg and lgs_cell.
module lgs_array import lgs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lgs_ctl_t          ctl_i,
  input  logic [FieldW-1:0] row_i,
  input  logic [FieldW-1:0] col_i,
  input  logic              wdata_i,
  output logic              rd_o
);

  logic [Rows-1:0][Cols-1:0] live;
  logic [Rows+1:0][Cols+1:0] pad;
  logic [Rows*Cols-1:0]      rd_bits;

  // Outside the grid counts as dead: no wraparound
  always_comb begin
    pad = '0;
    for (int r = 0; r < Rows; r++) begin
      for (int c = 0; c < Cols; c++) begin
        pad[r+1][c+1] = live[r][c];
      end
    end
  end

  for (genvar r = 0; r < Rows; r++) begin : g_row
    for (genvar c = 0; c < Cols; c++) begin : g_col
      logic [7:0] nbr;
      logic       sel;

      assign nbr = {pad[r][c],   pad[r][c+1],   pad[r][c+2],
                    pad[r+1][c],                pad[r+1][c+2],
                    pad[r+2][c], pad[r+2][c+1], pad[r+2][c+2]};
      assign sel = (32'(row_i) == 32'(r)) && (32'(col_i) == 32'(c));

      lgs_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctl_i   (ctl_i),
        .sel_i   (sel),
        .wdata_i (wdata_i),
        .nbr_i   (nbr),
        .live_o  (live[r][c]),
        .rd_o    (rd_bits[r*Cols+c])
      );
    end
  end

  assign rd_o = |rd_bits;

endmodule

// ----- hdl/life_grid_generation_step_top.sv -----
// Top level of the life grid generation step block.
// Depends on lgs_pkg and lgs_array.
//
// Usage: drive mode_i, row_i, col_i and cell_in_i and raise start_i; the
// command transfers at the rising edge where start_i is high and busy_o is
// low. busy_o stays low, so a new command may follow in every cycle.
// Commands: write one cell, read one cell, or advance the whole grid by one
// B3/S23 generation. Every site holds its own update logic and sees its
// eight neighbours, so the whole grid advances at once.
// Each command gives one result: res_valid_o is high for exactly one cycle,
// the cycle after the transfer, with cell_out_o (the cell read, else 0) and
// done_res_o (0 only for the unused mode code). Throughput is one command
// per cycle. Addresses beyond the grid are ignored on write and read as
// dead. The receiver cannot hold results off and must take each one in
// its cycle.
// Reset (rst_ni low, asynchronous) clears every cell to dead and drops the
// result strobe; commands may be issued in the first cycle after release.
module life_grid_generation_step_top import lgs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        mode_i,
  input  logic [FieldW-1:0] row_i,
  input  logic [FieldW-1:0] col_i,
  input  logic              cell_in_i,
  output logic              res_valid_o,
  output logic              cell_out_o,
  output logic              done_res_o
);

  logic      accept;
  lgs_mode_e mode;
  lgs_ctl_t  ctl;
  logic      rd_bit;
  logic      res_valid_q, res_valid_d;
  logic      cell_out_q, cell_out_d;
  logic      done_res_q, done_res_d;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;
  assign mode   = lgs_mode_e'(mode_i);

  always_comb begin
    ctl = '0;
    if (accept) begin
      unique case (mode)
        MODE_WRITE: ctl.write = 1'b1;
        MODE_READ:  ctl.read  = 1'b1;
        MODE_STEP:  ctl.step  = 1'b1;
        MODE_NONE:  ctl       = '0;
        default:    ctl       = '0;
      endcase
    end
  end

  lgs_array u_array (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .row_i   (row_i),
    .col_i   (col_i),
    .wdata_i (cell_in_i),
    .rd_o    (rd_bit)
  );

  assign res_valid_d = accept;
  assign cell_out_d  = rd_bit;
  assign done_res_d  = (mode != MODE_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  // Hold the result fields for the strobe cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cell_out_q <= cell_out_d;
      done_res_q <= done_res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign cell_out_o  = cell_out_q;
  assign done_res_o  = done_res_q;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> res_valid_o)
    else $error("transfer gave no result strobe");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !res_valid_o)
    else $error("result strobe without a transfer");

  a_live_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode != MODE_READ) |=> !cell_out_o)
    else $error("live cell reported for a non-read command");

  a_done_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (done_res_o == ($past(mode_i) != MODE_NONE)))
    else $error("done flag does not match command code");

endmodule

// ----- verif/life_grid_generation_step_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for life_grid_generation_step_top: cell writes, reads and
// B3/S23 generations, predicted from a private copy of the grid.
// Depends on lgs_pkg and the block's top level.
module life_grid_generation_step_top_tb;
  import lgs_pkg::*;

  typedef struct packed {
    logic cell_bit;
    logic done;
  } cell_result_t;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              start_i   = 1'b0;
  logic [1:0]        mode_i    = MODE_NONE;
  logic [FieldW-1:0] row_i     = '0;
  logic [FieldW-1:0] col_i     = '0;
  logic              cell_in_i = 1'b0;
  logic              busy_o;
  logic              res_valid_o;
  logic              cell_out_o;
  logic              done_res_o;

  logic [Cols-1:0] life_grid [Rows];
  cell_result_t    pending_results [$];
  int unsigned     mismatches = 0;
  bit              idle_off   = 1'b0;

  life_grid_generation_step_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .mode_i     (mode_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .cell_in_i  (cell_in_i),
    .res_valid_o(res_valid_o),
    .cell_out_o (cell_out_o),
    .done_res_o (done_res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    for (int r = 0; r < Rows; r++) life_grid[r] = '0;
  end

  // ---------------------------------------------------------------- grid predictor

  function automatic int unsigned live_neighbours(int r, int c);
    int unsigned n;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        // cells beyond the edge count as dead, no wraparound
        if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < Rows &&
            c + dc >= 0 && c + dc < Cols) begin
          n += 32'(life_grid[r + dr][c + dc]);
        end
      end
    end
    return n;
  endfunction

  function automatic void apply_generation();
    logic [Cols-1:0] next_grid [Rows];
    int unsigned     n;
    for (int r = 0; r < Rows; r++) begin
      for (int c = 0; c < Cols; c++) begin
        n = live_neighbours(r, c);
        if (n == 3) next_grid[r][c] = 1'b1;
        else if (n == 2) next_grid[r][c] = life_grid[r][c];
        else next_grid[r][c] = 1'b0;
      end
    end
    life_grid = next_grid;
  endfunction

  function automatic cell_result_t predict_command(lgs_mode_e mode, logic [FieldW-1:0] row,
                                                   logic [FieldW-1:0] col, logic cell_val);
    cell_result_t res;
    bit           on_grid;
    on_grid = (row < Rows) && (col < Cols);
    res.cell_bit = 1'b0;
    res.done     = 1'b1;
    case (mode)
      MODE_WRITE: if (on_grid) life_grid[row][col] = cell_val;
      MODE_READ:  if (on_grid) res.cell_bit = life_grid[row][col];
      MODE_STEP:  apply_generation();
      default:    res.done = 1'b0;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------- driving

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (idle_off || roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  // Hold start high across back-to-back transfers; drop it only for a gap.
  task automatic send_cmd(lgs_mode_e mode, logic [FieldW-1:0] row, logic [FieldW-1:0] col,
                          logic cell_val);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    mode_i    <= mode;
    row_i     <= row;
    col_i     <= col;
    cell_in_i <= cell_val;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(predict_command(mode, row, col, cell_val));
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    cell_result_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result strobe with no command outstanding");
      end else begin
        want = pending_results.pop_front();
        if (cell_out_o !== want.cell_bit)
          report_mismatch($sformatf("cell_out %b, predicted %b", cell_out_o, want.cell_bit));
        if (done_res_o !== want.done)
          report_mismatch($sformatf("done_res %b, predicted %b", done_res_o, want.done));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Corner block, blinkers on the right edge and in the interior, a lone cell in the
  // far corner, the unused code and reads of both extremes.
  task automatic test_directed_cases();
    send_cmd(MODE_READ,  5'd0,  5'd0,  1'b0);
    send_cmd(MODE_WRITE, 5'd0,  5'd0,  1'b1);
    send_cmd(MODE_WRITE, 5'd0,  5'd1,  1'b1);
    send_cmd(MODE_WRITE, 5'd1,  5'd0,  1'b1);
    send_cmd(MODE_WRITE, 5'd1,  5'd1,  1'b1);
    send_cmd(MODE_WRITE, 5'd15, 5'd31, 1'b1);
    send_cmd(MODE_WRITE, 5'd16, 5'd31, 1'b1);
    send_cmd(MODE_WRITE, 5'd17, 5'd31, 1'b1);
    send_cmd(MODE_WRITE, 5'd20, 5'd10, 1'b1);
    send_cmd(MODE_WRITE, 5'd20, 5'd11, 1'b1);
    send_cmd(MODE_WRITE, 5'd20, 5'd12, 1'b1);
    send_cmd(MODE_WRITE, 5'd31, 5'd31, 1'b1);
    send_cmd(MODE_NONE,  5'd31, 5'd31, 1'b1);
    send_cmd(MODE_STEP,  5'd0,  5'd0,  1'b0);
    send_cmd(MODE_READ,  5'd0,  5'd0,  1'b0);
    send_cmd(MODE_READ,  5'd16, 5'd30, 1'b0);
    send_cmd(MODE_READ,  5'd15, 5'd31, 1'b0);
    send_cmd(MODE_READ,  5'd19, 5'd11, 1'b0);
    send_cmd(MODE_READ,  5'd31, 5'd31, 1'b0);
    send_cmd(MODE_STEP,  5'd31, 5'd31, 1'b1);
    send_cmd(MODE_READ,  5'd20, 5'd11, 1'b0);
    send_cmd(MODE_READ,  5'd16, 5'd0,  1'b0);
    send_cmd(MODE_WRITE, 5'd0,  5'd0,  1'b0);
    send_cmd(MODE_READ,  5'd0,  5'd0,  1'b0);
  endtask

  // Let the block empty completely, then resume with reads across the grid.
  task automatic test_pause_until_idle();
    drain_results();
    repeat (8) send_cmd(MODE_READ, FieldW'($urandom), FieldW'($urandom), 1'b0);
  endtask

  // Seed a random soup in a window, then mix generations, reads, edits and noise.
  task automatic test_random_soup(int unsigned rounds);
    int unsigned r0, c0, h, w, density, roll;
    for (int unsigned k = 0; k < rounds; k++) begin
      idle_off = ($urandom_range(3) == 0);
      if ($urandom_range(4) == 0) begin
        h = Rows;
        w = Cols;
      end else begin
        h = $urandom_range(12, 3);
        w = $urandom_range(12, 3);
      end
      r0 = $urandom_range(Rows - h);
      c0 = $urandom_range(Cols - w);
      density = $urandom_range(70, 20);
      repeat (40) begin
        send_cmd(MODE_WRITE, FieldW'(r0 + $urandom_range(h - 1)),
                 FieldW'(c0 + $urandom_range(w - 1)), ($urandom_range(99) < density));
      end
      repeat (60) begin
        roll = $urandom_range(99);
        if (roll < 20) begin
          send_cmd(MODE_STEP, FieldW'($urandom), FieldW'($urandom), 1'($urandom));
        end else if (roll < 50) begin
          send_cmd(MODE_READ, FieldW'(r0 + $urandom_range(h - 1)),
                   FieldW'(c0 + $urandom_range(w - 1)), 1'($urandom));
        end else if (roll < 75) begin
          send_cmd(MODE_READ, FieldW'($urandom), FieldW'($urandom), 1'($urandom));
        end else if (roll < 94) begin
          send_cmd(MODE_WRITE, FieldW'(r0 + $urandom_range(h - 1)),
                   FieldW'(c0 + $urandom_range(w - 1)), 1'($urandom));
        end else begin
          send_cmd(MODE_NONE, FieldW'($urandom), FieldW'($urandom), 1'($urandom));
        end
      end
      if (k % 5 == 4) drain_results();
    end
    idle_off = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_pause_until_idle();
    test_random_soup(20);
    drain_results();
    repeat (5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
